[rtl/core/ltau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltau_pkg
// Types and constants shared by the line time attribution unit.
// ----------------------------------------------------------------------------
package ltau_pkg;

    localparam int TIME_W     = 64;
    localparam int FILE_W     = 2;
    localparam int LINE_NUM_W = 11;
    localparam int CLINE_W    = 10;

    // Slave-side tdata layout: file_id, line_number, time_now.
    localparam int IN_FILE_LSB = 0;
    localparam int IN_LINE_LSB = IN_FILE_LSB + FILE_W;
    localparam int IN_TIME_LSB = IN_LINE_LSB + LINE_NUM_W;
    localparam int IN_USED_W   = IN_TIME_LSB + TIME_W;
    localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;

    // Master-side tdata layout: status, charged, charged_line, charged_amount,
    // score_value.
    localparam int OUT_USED_W  = 1 + 1 + CLINE_W + TIME_W + TIME_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    localparam logic FUNC_EVENT = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_READ,
        S_PRED,
        S_SRCH_RD,
        S_SRCH_CHK,
        S_CH_RD,
        S_CH_CHK,
        S_CH_ADD,
        S_START,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              sub;
        logic [TIME_W-1:0] a;
        logic [TIME_W-1:0] b;
    } t_alu_req;

endpackage

[rtl/core/line_time_attribution_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_time_attribution_unit
// Per-line time profiler: charges elapsed time to the predecessor line of
// each line event and returns accumulated scores on read beats.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser = func; tdata = file_id, line_number, time_now
//  m_axis    out        tdata = status, charged, charged_line,
//                               charged_amount, score_value
//
// After reset a clearing pass writes all NUM_FILES * NUM_LINES entries (4096 by
// default) before the first beat is accepted.
// A read returns the stored score and an out-of-range beat only its status.
// An event uses its cached predecessor, or on a first visit searches the lower
// lines for the nearest pending start; a pending predecessor is then charged.
// A stalled master side holds the finished result and the sequencer.
// ----------------------------------------------------------------------------
module line_time_attribution_unit #(
    parameter int NUM_LINES = 1024,
    parameter int NUM_FILES = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [0] func
    input  logic                                i_s_axis_tuser,
    // [1:0] file_id, [12:2] line_number, [76:13] time_now, [79:77] zero
    input  logic [ltau_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [0] status, [1] charged, [11:2] charged_line, [75:12] charged_amount,
    // [139:76] score_value, [143:140] zero
    output logic [ltau_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata
);

    localparam int NUM_ENTRIES = NUM_FILES * NUM_LINES;
    localparam int AW          = $clog2(NUM_ENTRIES);
    localparam int IW          = $clog2(NUM_LINES);
    localparam int TW          = ltau_pkg::TIME_W;

    // Stores. The start store keeps the pending flag above the timestamp and
    // the predecessor store keeps the known flag above the index.
    logic [TW:0]   mem_start [NUM_ENTRIES];
    logic [IW:0]   mem_pred  [NUM_ENTRIES];
    logic [TW-1:0] mem_score [NUM_ENTRIES];

    ltau_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_clr, n_clr;
    logic             r_out_valid, n_out_valid;

    logic                  r_func, n_func;
    logic                  r_bad, n_bad;
    logic [AW-1:0]         r_base, n_base;
    logic [IW-1:0]         r_cidx, n_cidx;
    logic [TW-1:0]         r_now, n_now;
    logic [IW-1:0]         r_srch, n_srch;
    logic [IW-1:0]         r_pidx, n_pidx;
    logic [TW-1:0]         r_elapsed, n_elapsed;
    logic                  r_res_status, n_res_status;
    logic                  r_res_charged, n_res_charged;
    logic [TW-1:0]         r_res_amount, n_res_amount;
    logic [TW-1:0]         r_res_score, n_res_score;
    logic [ltau_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic [TW:0]   r_start_q;
    logic [IW:0]   r_pred_q;
    logic [TW-1:0] r_score_q;

    logic          start_we, pred_we, score_we;
    logic [AW-1:0] start_wa, pred_wa, score_wa;
    logic [AW-1:0] start_ra, pred_ra, score_ra;
    logic [TW:0]   start_wd;
    logic [IW:0]   pred_wd;
    logic [TW-1:0] score_wd;

    logic [AW-1:0] slot_addr, srch_addr, pidx_addr;
    logic          accept, out_free;
    logic [ltau_pkg::LINE_NUM_W-1:0] in_line;
    logic [ltau_pkg::FILE_W-1:0]     in_file;

    ltau_pkg::t_alu_req     alu_req;
    logic [TW-1:0]          alu_result;

    ltau_alu u_alu (
        .i_req    (alu_req),
        .o_result (alu_result)
    );

    assign o_s_axis_tready = (r_state == ltau_pkg::S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign in_file  = i_s_axis_tdata[ltau_pkg::IN_FILE_LSB +: ltau_pkg::FILE_W];
    assign in_line  = i_s_axis_tdata[ltau_pkg::IN_LINE_LSB +: ltau_pkg::LINE_NUM_W];

    assign slot_addr = r_base + AW'(r_cidx);
    assign srch_addr = r_base + AW'(r_srch);
    assign pidx_addr = r_base + AW'(r_pidx);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ltau_pkg::S_CLEAR: begin
                if (r_clr == AW'(NUM_ENTRIES - 1)) n_state = ltau_pkg::S_IDLE;
            end
            ltau_pkg::S_IDLE: begin
                if (accept) n_state = ltau_pkg::S_CHECK;
            end
            ltau_pkg::S_CHECK: begin
                if (r_bad)                              n_state = ltau_pkg::S_DONE;
                else if (r_func == ltau_pkg::FUNC_READ) n_state = ltau_pkg::S_READ;
                else                                    n_state = ltau_pkg::S_PRED;
            end
            ltau_pkg::S_READ: n_state = ltau_pkg::S_DONE;
            ltau_pkg::S_PRED: begin
                if (r_pred_q[IW])       n_state = ltau_pkg::S_CH_RD;
                else if (r_cidx == '0)  n_state = ltau_pkg::S_START;
                else                    n_state = ltau_pkg::S_SRCH_RD;
            end
            ltau_pkg::S_SRCH_RD: n_state = ltau_pkg::S_SRCH_CHK;
            ltau_pkg::S_SRCH_CHK: begin
                if (r_start_q[TW])      n_state = ltau_pkg::S_CH_RD;
                else if (r_srch == '0)  n_state = ltau_pkg::S_START;
                else                    n_state = ltau_pkg::S_SRCH_RD;
            end
            ltau_pkg::S_CH_RD: n_state = ltau_pkg::S_CH_CHK;
            ltau_pkg::S_CH_CHK: begin
                if (r_start_q[TW]) n_state = ltau_pkg::S_CH_ADD;
                else               n_state = ltau_pkg::S_START;
            end
            ltau_pkg::S_CH_ADD: n_state = ltau_pkg::S_START;
            ltau_pkg::S_START:  n_state = ltau_pkg::S_DONE;
            ltau_pkg::S_DONE: begin
                if (out_free) n_state = ltau_pkg::S_IDLE;
            end
            default: n_state = ltau_pkg::S_IDLE;
        endcase
    end

    // Datapath and store control.
    always_comb begin
        n_clr         = r_clr;
        n_func        = r_func;
        n_bad         = r_bad;
        n_base        = r_base;
        n_cidx        = r_cidx;
        n_now         = r_now;
        n_srch        = r_srch;
        n_pidx        = r_pidx;
        n_elapsed     = r_elapsed;
        n_res_status  = r_res_status;
        n_res_charged = r_res_charged;
        n_res_amount  = r_res_amount;
        n_res_score   = r_res_score;
        n_out_data    = r_out_data;
        n_out_valid   = r_out_valid && !i_m_axis_tready;

        start_we = 1'b0;
        start_wa = slot_addr;
        start_wd = {1'b1, r_now};
        pred_we  = 1'b0;
        pred_wa  = slot_addr;
        pred_wd  = {1'b1, r_srch};
        score_we = 1'b0;
        score_wa = pidx_addr;
        score_wd = alu_result;
        start_ra = pidx_addr;
        pred_ra  = slot_addr;
        score_ra = slot_addr;

        alu_req.sub = 1'b0;
        alu_req.a   = r_score_q;
        alu_req.b   = r_elapsed;

        unique case (r_state)
            ltau_pkg::S_CLEAR: begin
                start_we = 1'b1;
                start_wa = r_clr;
                start_wd = '0;
                pred_we  = 1'b1;
                pred_wa  = r_clr;
                pred_wd  = '0;
                score_we = 1'b1;
                score_wa = r_clr;
                score_wd = '0;
                n_clr    = r_clr + AW'(1);
            end
            ltau_pkg::S_IDLE: begin
                if (accept) begin
                    n_func = i_s_axis_tuser;
                    n_bad  = (32'(in_line) == 32'd0) || (32'(in_line) > NUM_LINES)
                             || (32'(in_file) >= NUM_FILES);
                    n_base = AW'(32'(in_file) * NUM_LINES);
                    n_cidx = IW'(32'(in_line) - 32'd1);
                    n_now  = i_s_axis_tdata[ltau_pkg::IN_TIME_LSB +: TW];
                end
            end
            ltau_pkg::S_CHECK: begin
                n_res_status  = r_bad;
                n_res_charged = 1'b0;
                n_res_amount  = '0;
                n_res_score   = '0;
            end
            ltau_pkg::S_READ: begin
                n_res_score = r_score_q;
            end
            ltau_pkg::S_PRED: begin
                n_pidx = r_pred_q[IW-1:0];
                n_srch = r_cidx - IW'(1);
            end
            ltau_pkg::S_SRCH_RD: begin
                start_ra = srch_addr;
            end
            ltau_pkg::S_SRCH_CHK: begin
                if (r_start_q[TW]) begin
                    // Nearest lower line with a pending start becomes the cache.
                    n_pidx  = r_srch;
                    pred_we = 1'b1;
                end else begin
                    n_srch = r_srch - IW'(1);
                end
            end
            ltau_pkg::S_CH_RD: begin
                start_ra = pidx_addr;
            end
            ltau_pkg::S_CH_CHK: begin
                alu_req.sub = 1'b1;
                alu_req.a   = r_now;
                alu_req.b   = r_start_q[TW-1:0];
                n_elapsed   = alu_result;
                score_ra    = pidx_addr;
            end
            ltau_pkg::S_CH_ADD: begin
                score_we      = 1'b1;
                start_we      = 1'b1;
                start_wa      = pidx_addr;
                start_wd      = {1'b0, r_now};
                n_res_charged = 1'b1;
                n_res_amount  = r_elapsed;
            end
            ltau_pkg::S_START: begin
                start_we = 1'b1;
            end
            ltau_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {{ltau_pkg::OUT_PAD_W{1'b0}}, r_res_score, r_res_amount,
                                   (r_res_charged ? ltau_pkg::CLINE_W'(r_pidx)
                                                  : ltau_pkg::CLINE_W'(0)),
                                   r_res_charged, r_res_status};
                end
            end
            default: begin
                n_clr = r_clr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ltau_pkg::S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_bad         <= n_bad;
        r_base        <= n_base;
        r_cidx        <= n_cidx;
        r_now         <= n_now;
        r_srch        <= n_srch;
        r_pidx        <= n_pidx;
        r_elapsed     <= n_elapsed;
        r_res_status  <= n_res_status;
        r_res_charged <= n_res_charged;
        r_res_amount  <= n_res_amount;
        r_res_score   <= n_res_score;
        r_out_data    <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (start_we) mem_start[start_wa] <= start_wd;
        r_start_q <= mem_start[start_ra];
    end

    always_ff @(posedge i_clk) begin
        if (pred_we) mem_pred[pred_wa] <= pred_wd;
        r_pred_q <= mem_pred[pred_ra];
    end

    always_ff @(posedge i_clk) begin
        if (score_we) mem_score[score_wa] <= score_wd;
        r_score_q <= mem_score[score_ra];
    end

endmodule

[rtl/core/ltau_alu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltau_alu
// Shared 64-bit adder and subtractor, wrapping modulo 2^64.
// ----------------------------------------------------------------------------
module ltau_alu (
    input  ltau_pkg::t_alu_req           i_req,
    output logic [ltau_pkg::TIME_W-1:0]  o_result
);

    logic [ltau_pkg::TIME_W-1:0] w_b;

    always_comb begin
        w_b      = i_req.sub ? ~i_req.b : i_req.b;
        o_result = i_req.a + w_b + ltau_pkg::TIME_W'(i_req.sub);
    end

endmodule

[rtl/core/ltau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltau_checker
// Port-level checks for the line time attribution unit, bound to the top.
// ----------------------------------------------------------------------------
module ltau_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_axis_tvalid,
    input logic                              o_s_axis_tready,
    input logic                              i_s_axis_tuser,
    input logic [ltau_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [ltau_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    // A result beat that is held back keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result beat changed while stalled");

    // Only one item is worked on at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again right after an accepted beat");

    // An ignored item reports nothing but its status.
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[0] |-> o_m_axis_tdata[139:1] == '0)
        else $error("out-of-range result carries data");

    // Without a charge the charged line and amount stay zero.
    a_no_charge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[1] |-> o_m_axis_tdata[75:2] == '0)
        else $error("charge fields set without a charge");

    // A charging event never returns a score.
    a_charge_no_score: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[1] |-> o_m_axis_tdata[143:76] == '0)
        else $error("charging event returned a score");

endmodule

bind line_time_attribution_unit ltau_checker u_ltau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

[dv/tb_line_time_attribution_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_time_attribution_unit
// Self-checking bench for the per-line time profiler. A short table of
// directed beats covers reset state, range errors, first-visit searches,
// cached predecessors and timestamp wrap. Random traffic follows: mostly
// line walks with rising per-file clocks, mixed with reads, out-of-range
// beats and random timestamps. Each result is checked against its table entry
// or against a local model of the score, start and predecessor stores, under
// changing back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_line_time_attribution_unit;

    localparam int NUM_LINES   = 1024;
    localparam int NUM_FILES   = 4;
    localparam int NUM_ENTRIES = NUM_LINES * NUM_FILES;
    localparam int RAND_ITEMS  = 500;
    localparam int WALK_SPAN   = 40;
    localparam int DRAIN       = 16;
    localparam int LIMIT       = 4000000;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_RANGE = 1'b1;

    // Master-side field offsets.
    localparam int OUT_CHG_LSB   = 1;
    localparam int OUT_CLINE_LSB = 2;
    localparam int OUT_AMT_LSB   = OUT_CLINE_LSB + ltau_pkg::CLINE_W;
    localparam int OUT_SCORE_LSB = OUT_AMT_LSB + ltau_pkg::TIME_W;

    typedef struct packed {
        logic                            func;
        logic [ltau_pkg::FILE_W-1:0]     file;
        logic [ltau_pkg::LINE_NUM_W-1:0] line;
        logic [ltau_pkg::TIME_W-1:0]     tnow;
    } t_item;

    typedef struct packed {
        logic                         status;
        logic                         charged;
        logic [ltau_pkg::CLINE_W-1:0] cline;
        logic [ltau_pkg::TIME_W-1:0]  amount;
        logic [ltau_pkg::TIME_W-1:0]  score;
    } t_result;

    typedef struct packed {
        t_item   beat;
        logic    typed;
        t_result exp;
    } t_row;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_user = 1'b0;
    logic [ltau_pkg::IN_TDATA_W-1:0]  s_data = '0;
    logic                             m_ready = 1'b0;
    logic                             o_s_axis_tready;
    logic                             o_m_axis_tvalid;
    logic [ltau_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Profiler state as the block should hold it.
    logic [ltau_pkg::TIME_W-1:0]  line_score [NUM_ENTRIES];
    logic [ltau_pkg::TIME_W-1:0]  line_start [NUM_ENTRIES];
    logic                         start_open [NUM_ENTRIES];
    logic [ltau_pkg::CLINE_W-1:0] pred_line  [NUM_ENTRIES];
    logic                         pred_valid [NUM_ENTRIES];

    t_result expected_results[$];
    t_row    dir_plan[$];

    int send_idle_pct = 9;
    int recv_idle_pct = 74;
    int errors = 0;
    int cycles = 0;
    int n_events = 0;
    int n_reads = 0;
    int n_range = 0;
    int n_charges = 0;

    line_time_attribution_unit #(
        .NUM_LINES(NUM_LINES),
        .NUM_FILES(NUM_FILES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tuser (s_user),
        .i_s_axis_tdata (s_data),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding.", cycles,
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Charges elapsed time to the predecessor of a line, or returns a score.
    function automatic t_result attribute_line(t_item it);
        t_result r;
        int      base;
        int      cidx;
        int      slot;
        int      pidx;
        logic    found;
        r = '0;
        if (it.line == 0 || it.line > NUM_LINES || it.file >= NUM_FILES) begin
            r.status = STATUS_RANGE;
            return r;
        end
        cidx = int'(it.line) - 1;
        base = int'(it.file) * NUM_LINES;
        slot = base + cidx;
        if (it.func == ltau_pkg::FUNC_READ) begin
            r.score = line_score[slot];
            return r;
        end
        found = pred_valid[slot];
        pidx  = int'(pred_line[slot]);
        // The downward search only runs while no predecessor is cached.
        if (!found) begin
            for (int i = cidx - 1; i >= 0 && !found; i--) begin
                if (start_open[base + i]) begin
                    found = 1'b1;
                    pidx  = i;
                    pred_line[slot]  = ltau_pkg::CLINE_W'(i);
                    pred_valid[slot] = 1'b1;
                end
            end
        end
        line_start[slot] = it.tnow;
        start_open[slot] = 1'b1;
        if (found && start_open[base + pidx]) begin
            r.charged = 1'b1;
            r.cline   = ltau_pkg::CLINE_W'(pidx);
            r.amount  = it.tnow - line_start[base + pidx];
            line_score[base + pidx] += r.amount;
            start_open[base + pidx] = 1'b0;
        end
        return r;
    endfunction

    task automatic send_beat(input t_item it, input logic typed, input t_result typed_exp);
        t_result                         pred;
        logic [ltau_pkg::IN_TDATA_W-1:0] data;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        data = '0;
        data[ltau_pkg::IN_FILE_LSB +: ltau_pkg::FILE_W]     = it.file;
        data[ltau_pkg::IN_LINE_LSB +: ltau_pkg::LINE_NUM_W] = it.line;
        data[ltau_pkg::IN_TIME_LSB +: ltau_pkg::TIME_W]     = it.tnow;
        s_valid <= 1'b1;
        s_user  <= it.func;
        s_data  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pred = attribute_line(it);
        if (pred.status == STATUS_RANGE) n_range++;
        else if (it.func == ltau_pkg::FUNC_READ) n_reads++;
        else n_events++;
        expected_results.push_back(typed ? typed_exp : pred);
    endtask

    // Output side: random back-pressure and result checking.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            if (o_m_axis_tvalid && m_ready) begin
                got.status  = o_m_axis_tdata[0];
                got.charged = o_m_axis_tdata[OUT_CHG_LSB];
                got.cline   = o_m_axis_tdata[OUT_CLINE_LSB +: ltau_pkg::CLINE_W];
                got.amount  = o_m_axis_tdata[OUT_AMT_LSB +: ltau_pkg::TIME_W];
                got.score   = o_m_axis_tdata[OUT_SCORE_LSB +: ltau_pkg::TIME_W];
                if (expected_results.size() == 0) begin
                    $error("Result beat with nothing expected: %h", got);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.charged) n_charges++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.charged !== want.charged) begin
                        $error("charged: expected %0d, got %0d", want.charged, got.charged);
                        errors++;
                    end
                    if (got.cline !== want.cline) begin
                        $error("charged_line: expected %0d, got %0d", want.cline, got.cline);
                        errors++;
                    end
                    if (got.amount !== want.amount) begin
                        $error("charged_amount: expected %h, got %h", want.amount, got.amount);
                        errors++;
                    end
                    if (got.score !== want.score) begin
                        $error("score_value: expected %h, got %h", want.score, got.score);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        t_item                       it;
        int                          roll;
        int                          f;
        int                          step;
        int                          walk [NUM_FILES];
        logic [ltau_pkg::TIME_W-1:0] file_clock [NUM_FILES];

        for (int i = 0; i < NUM_ENTRIES; i++) begin
            line_score[i] = '0;
            line_start[i] = '0;
            start_open[i] = 1'b0;
            pred_line[i]  = '0;
            pred_valid[i] = 1'b0;
        end
        for (int i = 0; i < NUM_FILES; i++) begin
            walk[i]       = 1;
            file_clock[i] = {$urandom, $urandom};
        end

        dir_plan = '{
            // Fresh state: a read returns zero, range errors carry only status.
            '{'{ltau_pkg::FUNC_READ,  2'd0, 11'd1,    64'd0},  1'b1,
              '{STATUS_OK, 1'b0, 10'd0, 64'd0, 64'd0}},
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd0,    64'd7},  1'b1,
              '{STATUS_RANGE, 1'b0, 10'd0, 64'd0, 64'd0}},
            '{'{ltau_pkg::FUNC_EVENT, 2'd2, 11'd1025, 64'd9},  1'b1,
              '{STATUS_RANGE, 1'b0, 10'd0, 64'd0, 64'd0}},
            '{'{ltau_pkg::FUNC_READ,  2'd3, 11'd2047, '1},     1'b1,
              '{STATUS_RANGE, 1'b0, 10'd0, 64'd0, 64'd0}},
            '{'{ltau_pkg::FUNC_READ,  2'd1, 11'd0,    64'd0},  1'b1,
              '{STATUS_RANGE, 1'b0, 10'd0, 64'd0, 64'd0}},
            // Line one has nothing below it, so nothing is charged.
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd1,    64'd100}, 1'b1,
              '{STATUS_OK, 1'b0, 10'd0, 64'd0, 64'd0}},
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd2,    64'd250}, 1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd2,    64'd300}, 1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd1,    64'd400}, 1'b0, '0},
            // Earlier timestamp than the pending start: the charge wraps.
            '{'{ltau_pkg::FUNC_EVENT, 2'd0, 11'd2,    64'd50},  1'b0, '0},
            '{'{ltau_pkg::FUNC_READ,  2'd0, 11'd1,    64'd0},   1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd1, 11'd1024, '1},      1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd1, 11'd1023, 64'd0},   1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd1, 11'd1024, 64'd5},   1'b0, '0},
            '{'{ltau_pkg::FUNC_READ,  2'd1, 11'd1023, '1},      1'b0, '0},
            '{'{ltau_pkg::FUNC_READ,  2'd1, 11'd1024, 64'd3},   1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd3, 11'd5,    64'h8000_0000_0000_0000}, 1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd3, 11'd9,    '1},      1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd3, 11'd7,    64'd1},   1'b0, '0},
            '{'{ltau_pkg::FUNC_READ,  2'd3, 11'd5,    64'd0},   1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd2, 11'd1024, 64'h5555_5555_5555_5555}, 1'b0, '0},
            '{'{ltau_pkg::FUNC_EVENT, 2'd2, 11'd512,  64'haaaa_aaaa_aaaa_aaaa}, 1'b0, '0},
            '{'{ltau_pkg::FUNC_READ,  2'd2, 11'd512,  64'd0},   1'b0, '0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_plan[i]) send_beat(dir_plan[i].beat, dir_plan[i].typed, dir_plan[i].exp);

        for (int k = 0; k < RAND_ITEMS; k++) begin
            if (k == RAND_ITEMS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 9;
            end
            if (k == 2 * RAND_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            roll    = $urandom_range(99);
            f       = $urandom_range(NUM_FILES - 1);
            it.file = ltau_pkg::FILE_W'(f);
            it.func = ltau_pkg::FUNC_EVENT;
            it.tnow = {$urandom, $urandom};
            if (roll < 70) begin
                // Program-like walk: mostly the next line, sometimes a loop back.
                step = $urandom_range(9);
                if (step < 6) walk[f] = (walk[f] >= WALK_SPAN) ? 1 : walk[f] + 1;
                else if (step < 8) walk[f] = $urandom_range(WALK_SPAN, 1);
                it.line       = ltau_pkg::LINE_NUM_W'(walk[f]);
                file_clock[f] = file_clock[f]
                                + ltau_pkg::TIME_W'($urandom_range(100000, 1));
                it.tnow       = file_clock[f];
            end else if (roll < 85) begin
                it.func = ltau_pkg::FUNC_READ;
                it.line = ltau_pkg::LINE_NUM_W'(($urandom_range(19) == 0)
                                                ? 1024 : $urandom_range(WALK_SPAN, 1));
            end else if (roll < 92) begin
                it.func = 1'($urandom_range(1));
                it.line = ltau_pkg::LINE_NUM_W'($urandom_range(1)
                                                ? 0 : $urandom_range(2047, 1025));
            end else if (roll < 95) begin
                // High lines make the first-visit search walk a long way down.
                it.line       = ltau_pkg::LINE_NUM_W'($urandom_range(1024, 1000));
                file_clock[f] = file_clock[f]
                                + ltau_pkg::TIME_W'($urandom_range(100000, 1));
                it.tnow       = file_clock[f];
            end else begin
                it.line = ltau_pkg::LINE_NUM_W'($urandom_range(WALK_SPAN, 1));
            end
            send_beat(it, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Ran %0d line events, %0d score reads and %0d out-of-range beats;",
                 n_events, n_reads, n_range);
        $display("%0d results charged time to a predecessor line.", n_charges);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
